### design/terrain_sloped_height_assert.svh
// Assertion macros shared by the terrain height checker.
`ifndef TERRAIN_SLOPED_HEIGHT_ASSERT_SVH
`define TERRAIN_SLOPED_HEIGHT_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define TSH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define TSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also runs during reset.
`define TSH_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/tsh_pkg.sv
// Shared constants for the terrain sloped height block.
package tsh_pkg;

    // Field widths.
    localparam int PosW    = 16;
    localparam int BaseW   = 8;
    localparam int WaterW  = 5;
    localparam int CornerW = 4;
    localparam int HeightW = 11;
    localparam int WhW     = 9;

    // Coordinates at or above this unsigned value lie off the map.
    localparam logic [PosW-1:0] MAP_LIMIT = 16'd12287;

    // Result for off-map points or tiles without a surface.
    localparam logic [HeightW-1:0] DEFAULT_HEIGHT = 11'd16;

    // Largest height any slope case can produce.
    localparam logic [HeightW-1:0] MAX_HEIGHT = 11'd1052;

    // Slope codes taken from the raised-corner bits.
    localparam logic [CornerW-1:0] SLOPE_FLAT = 4'd0;
    localparam logic [CornerW-1:0] SLOPE_N    = 4'd1;
    localparam logic [CornerW-1:0] SLOPE_E    = 4'd2;
    localparam logic [CornerW-1:0] SLOPE_NE   = 4'd3;
    localparam logic [CornerW-1:0] SLOPE_S    = 4'd4;
    localparam logic [CornerW-1:0] SLOPE_NS   = 4'd5;
    localparam logic [CornerW-1:0] SLOPE_SE   = 4'd6;
    localparam logic [CornerW-1:0] SLOPE_WDN  = 4'd7;
    localparam logic [CornerW-1:0] SLOPE_W    = 4'd8;
    localparam logic [CornerW-1:0] SLOPE_NW   = 4'd9;
    localparam logic [CornerW-1:0] SLOPE_WE   = 4'd10;
    localparam logic [CornerW-1:0] SLOPE_SDN  = 4'd11;
    localparam logic [CornerW-1:0] SLOPE_SW   = 4'd12;
    localparam logic [CornerW-1:0] SLOPE_EDN  = 4'd13;
    localparam logic [CornerW-1:0] SLOPE_NDN  = 4'd14;
    localparam logic [CornerW-1:0] SLOPE_FULL = 4'd15;

endpackage

### design/tsh_calc.sv
// Combinational height and water height for one registered request.
module tsh_calc (
    input  logic [tsh_pkg::PosW-1:0]    i_pos_x,
    input  logic [tsh_pkg::PosW-1:0]    i_pos_y,
    input  logic                        i_surface_present,
    input  logic [tsh_pkg::BaseW-1:0]   i_base_level,
    input  logic [tsh_pkg::WaterW-1:0]  i_water_level,
    input  logic [tsh_pkg::CornerW-1:0] i_corner_bits,
    input  logic                        i_double_height,
    output logic [tsh_pkg::HeightW-1:0] o_height,
    output logic [tsh_pkg::WhW-1:0]     o_water_height
);

    // Halve a signed value, truncating toward zero.
    function automatic logic signed [7:0] half_tz(input logic signed [7:0] v);
        logic signed [7:0] adj;
        adj = v + $signed({7'b0, v[7]});
        return adj >>> 1;
    endfunction

    logic signed [7:0]  xl;
    logic signed [7:0]  yl;
    logic signed [7:0]  q;
    logic signed [7:0]  e;
    logic signed [7:0]  delta;
    logic signed [11:0] h_sum;
    logic               off_map;

    assign xl = $signed({3'b0, i_pos_x[4:0]});
    assign yl = $signed({3'b0, i_pos_y[4:0]});

    // Height offset inside the tile for each slope shape.
    always_comb begin
        q     = '0;
        e     = '0;
        delta = '0;
        unique case (i_corner_bits)
            tsh_pkg::SLOPE_N, tsh_pkg::SLOPE_E, tsh_pkg::SLOPE_S, tsh_pkg::SLOPE_W: begin
                unique case (i_corner_bits)
                    tsh_pkg::SLOPE_N: q = xl + yl - 8'sd31;
                    tsh_pkg::SLOPE_E: q = xl - yl;
                    tsh_pkg::SLOPE_S: q = 8'sd31 - yl - xl;
                    default:          q = yl - xl;
                endcase
                if (q > 8'sd0) begin
                    delta = half_tz(q);
                end
            end
            tsh_pkg::SLOPE_NE: delta = half_tz(xl) + 8'sd1;
            tsh_pkg::SLOPE_SE: delta = half_tz(8'sd31 - yl);
            tsh_pkg::SLOPE_NW: delta = half_tz(yl) + 8'sd1;
            tsh_pkg::SLOPE_SW: delta = half_tz(8'sd31 - xl);
            tsh_pkg::SLOPE_WDN, tsh_pkg::SLOPE_SDN, tsh_pkg::SLOPE_EDN,
            tsh_pkg::SLOPE_NDN: begin
                unique case (i_corner_bits)
                    tsh_pkg::SLOPE_WDN: begin
                        e = xl + 8'sd31 - yl;
                        q = xl - yl;
                    end
                    tsh_pkg::SLOPE_SDN: begin
                        e = xl + yl;
                        q = xl + yl - 8'sd32;
                    end
                    tsh_pkg::SLOPE_EDN: begin
                        e = 8'sd31 - xl + yl;
                        q = yl - xl;
                    end
                    default: begin
                        e = 8'sd62 - xl - yl;
                        q = 8'sd30 - xl - yl;
                    end
                endcase
                if (i_double_height) begin
                    delta = half_tz(e) + 8'sd1;
                end else if (q < 8'sd0) begin
                    delta = 8'sd16 + half_tz(q);
                end else begin
                    delta = 8'sd16;
                end
            end
            tsh_pkg::SLOPE_NS: begin
                q = xl - yl;
                if (q > 8'sd0) begin
                    delta = half_tz(q);
                end
            end
            // Flat, full and the west-east valley leave the base height alone.
            default: delta = '0;
        endcase
    end

    // Base height plus the in-tile offset; never negative.
    assign h_sum = $signed({2'b0, i_base_level, 2'b0}) + {{4{delta[7]}}, delta};

    assign off_map = (i_pos_x >= tsh_pkg::MAP_LIMIT) || (i_pos_y >= tsh_pkg::MAP_LIMIT)
                     || !i_surface_present;

    // Off-map points and missing surfaces get the default result.
    always_comb begin
        if (off_map) begin
            o_height       = tsh_pkg::DEFAULT_HEIGHT;
            o_water_height = '0;
        end else begin
            o_height       = h_sum[tsh_pkg::HeightW-1:0];
            o_water_height = {i_water_level, 4'b0};
        end
    end

endmodule

### design/terrain_sloped_height.sv
// Top level of the terrain sloped height lookup.
// Takes one request per cycle and returns terrain and water height at a world point.
// The result is presented from the result register. The input register takes the request
// at the accepting edge. The slope arithmetic runs between that register and the result
// register, which loads when it is empty or its result is being taken. Throughput is one
// request per clock for as long as the result side keeps taking results. A stalled
// result holds the pipeline, and ready falls only when both registers are full and the
// result is not being taken.
module terrain_sloped_height (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tsh_pkg::PosW-1:0]    i_pos_x,
    input  logic [tsh_pkg::PosW-1:0]    i_pos_y,
    input  logic                        i_surface_present,
    input  logic [tsh_pkg::BaseW-1:0]   i_base_level,
    input  logic [tsh_pkg::WaterW-1:0]  i_water_level,
    input  logic [tsh_pkg::CornerW-1:0] i_corner_bits,
    input  logic                        i_double_height,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tsh_pkg::HeightW-1:0] o_height,
    output logic [tsh_pkg::WhW-1:0]     o_water_height
);

    logic                        r_s1_valid;
    logic [tsh_pkg::PosW-1:0]    r_pos_x;
    logic [tsh_pkg::PosW-1:0]    r_pos_y;
    logic                        r_surface_present;
    logic [tsh_pkg::BaseW-1:0]   r_base_level;
    logic [tsh_pkg::WaterW-1:0]  r_water_level;
    logic [tsh_pkg::CornerW-1:0] r_corner_bits;
    logic                        r_double_height;
    logic                        r_out_valid;
    logic [tsh_pkg::HeightW-1:0] r_height;
    logic [tsh_pkg::WhW-1:0]     r_water_height;
    logic [tsh_pkg::HeightW-1:0] n_height;
    logic [tsh_pkg::WhW-1:0]     n_water_height;
    logic                        s1_ready;
    logic                        s2_ready;

    // Each stage advances when the stage after it is empty or draining.
    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (s1_ready && i_in_valid) begin
            r_pos_x           <= i_pos_x;
            r_pos_y           <= i_pos_y;
            r_surface_present <= i_surface_present;
            r_base_level      <= i_base_level;
            r_water_level     <= i_water_level;
            r_corner_bits     <= i_corner_bits;
            r_double_height   <= i_double_height;
        end
    end

    // Slope arithmetic.
    tsh_calc u_calc (
        .i_pos_x           (r_pos_x),
        .i_pos_y           (r_pos_y),
        .i_surface_present (r_surface_present),
        .i_base_level      (r_base_level),
        .i_water_level     (r_water_level),
        .i_corner_bits     (r_corner_bits),
        .i_double_height   (r_double_height),
        .o_height          (n_height),
        .o_water_height    (n_water_height)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            r_height       <= n_height;
            r_water_height <= n_water_height;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_height       = r_height;
    assign o_water_height = r_water_height;

endmodule

### design/tsh_checker.sv
// Port-level checks for the terrain sloped height block, bound to the top level.
`include "terrain_sloped_height_assert.svh"

module tsh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [tsh_pkg::PosW-1:0]    i_pos_x,
    input logic [tsh_pkg::PosW-1:0]    i_pos_y,
    input logic                        i_surface_present,
    input logic [tsh_pkg::BaseW-1:0]   i_base_level,
    input logic [tsh_pkg::WaterW-1:0]  i_water_level,
    input logic [tsh_pkg::CornerW-1:0] i_corner_bits,
    input logic                        i_double_height,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [tsh_pkg::HeightW-1:0] o_height,
    input logic [tsh_pkg::WhW-1:0]     o_water_height
);

    logic [tsh_pkg::HeightW+tsh_pkg::WhW-1:0] out_word;

    // Both result fields side by side, so one check covers the whole result.
    assign out_word = {o_height, o_water_height};

    // A stalled result keeps its valid and its value.
    `TSH_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_word))

    // Reset leaves no result pending.
    `TSH_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid)

    // Water height is always a whole number of levels.
    `TSH_ASSERT_IMP(a_water_step, o_out_valid, o_water_height[3:0] == 4'd0)

    // No slope case can push the height past its maximum.
    `TSH_ASSERT_IMP(a_height_range, o_out_valid, o_height <= tsh_pkg::MAX_HEIGHT)

    // With no result waiting, the input side is always ready.
    `TSH_ASSERT_IMP(a_ready_when_idle, !o_out_valid, o_in_ready)

endmodule

bind terrain_sloped_height tsh_checker u_tsh_checker (.*);

### sim/terrain_sloped_height_checker.sv
// Checker for the terrain height block: predicts every request and compares results.
module terrain_sloped_height_checker
    import tsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [PosW-1:0]    i_pos_x,
    input  logic [PosW-1:0]    i_pos_y,
    input  logic               i_surface_present,
    input  logic [BaseW-1:0]   i_base_level,
    input  logic [WaterW-1:0]  i_water_level,
    input  logic [CornerW-1:0] i_corner_bits,
    input  logic               i_double_height,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [HeightW-1:0] i_height,
    input  logic [WhW-1:0]     i_water_height,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Largest subtile offset; a tile spans 32 units.
    localparam int TILE_SPAN = 31;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [HeightW-1:0] height;
        logic [WhW-1:0]     water;
    } height_pair_t;

    // Heights predicted for requests that have not come back yet, oldest first.
    height_pair_t pending_heights[$];
    int fail_count = 0;

    initial o_pending = 0;
    assign o_fail_count = fail_count;

    // Terrain and water height at one point, from the tile fields.
    function automatic height_pair_t terrain_height_at(
        input logic [PosW-1:0]    px,
        input logic [PosW-1:0]    py,
        input logic               present,
        input logic [BaseW-1:0]   base,
        input logic [WaterW-1:0]  water,
        input logic [CornerW-1:0] corners,
        input logic               dbl
    );
        height_pair_t r;
        int xl, yl, q, e, h;
        if (px >= MAP_LIMIT || py >= MAP_LIMIT || !present) begin
            r.height = DEFAULT_HEIGHT;
            r.water  = '0;
            return r;
        end
        xl = int'(px[4:0]);
        yl = int'(py[4:0]);
        h  = int'(base) * 4;
        case (corners)
            // One corner raised: the point climbs only on the raised half.
            SLOPE_N, SLOPE_E, SLOPE_S, SLOPE_W: begin
                if (corners == SLOPE_N)      q = xl + yl - TILE_SPAN;
                else if (corners == SLOPE_E) q = xl - yl;
                else if (corners == SLOPE_S) q = TILE_SPAN - yl - xl;
                else                         q = yl - xl;
                if (q > 0) h += q / 2;
            end
            // One side raised: a plain ramp across the tile.
            SLOPE_NE: h += xl / 2 + 1;
            SLOPE_SE: h += (TILE_SPAN - yl) / 2;
            SLOPE_NW: h += yl / 2 + 1;
            SLOPE_SW: h += (TILE_SPAN - xl) / 2;
            // One corner lowered, optionally steep.
            SLOPE_WDN, SLOPE_SDN, SLOPE_EDN, SLOPE_NDN: begin
                if (corners == SLOPE_WDN) begin
                    e = xl + TILE_SPAN - yl;
                    q = xl - yl;
                end else if (corners == SLOPE_SDN) begin
                    e = xl + yl;
                    q = xl + yl - TILE_SPAN - 1;
                end else if (corners == SLOPE_EDN) begin
                    e = TILE_SPAN - xl + yl;
                    q = yl - xl;
                end else begin
                    e = (TILE_SPAN - xl) + (TILE_SPAN - yl);
                    q = TILE_SPAN - yl - xl - 1;
                end
                if (dbl) begin
                    h += e / 2 + 1;
                end else begin
                    h += 16;
                    if (q < 0) h += q / 2;
                end
            end
            // Valleys.
            SLOPE_WE: begin
                if (xl + yl > TILE_SPAN + 1) begin
                    q = TILE_SPAN - xl - yl;
                    if (q > 0) h += q / 2;
                end
            end
            SLOPE_NS: begin
                q = xl - yl;
                if (q > 0) h += q / 2;
            end
            default: ;
        endcase
        r.height = h[HeightW-1:0];
        r.water  = {water, 4'b0000};
        return r;
    endfunction

    task automatic report_failure(input string msg);
        if (fail_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Results are checked before the request of the same edge is queued, so an
    // early result can never be matched against its own request.
    always @(posedge i_clk) begin : monitor
        height_pair_t want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_heights.size() == 0) begin
                    report_failure($sformatf(
                        "result with no request waiting: height=%0d water=%0d",
                        i_height, i_water_height));
                end else begin
                    want = pending_heights.pop_front();
                    if (want.height !== i_height || want.water !== i_water_height)
                        report_failure($sformatf(
                            "mismatch: expected height=%0d water=%0d, got height=%0d water=%0d",
                            want.height, want.water, i_height, i_water_height));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_heights.push_back(terrain_height_at(i_pos_x, i_pos_y, i_surface_present,
                                                            i_base_level, i_water_level,
                                                            i_corner_bits, i_double_height));
            o_pending <= pending_heights.size();
        end
    end

endmodule

### sim/tb.sv
// Testbench top for the terrain height block: clock, reset, requests, stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsh_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD_OFF = 64;
    localparam int DRAIN_CYCLES  = 6;
    localparam int PHASE_ITEMS   = 275;

    typedef struct {
        logic [PosW-1:0]    pos_x;
        logic [PosW-1:0]    pos_y;
        logic               present;
        logic [BaseW-1:0]   base;
        logic [WaterW-1:0]  water;
        logic [CornerW-1:0] corners;
        logic               dbl;
    } terrain_request_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [PosW-1:0]    i_pos_x = '0;
    logic [PosW-1:0]    i_pos_y = '0;
    logic               i_surface_present = 1'b0;
    logic [BaseW-1:0]   i_base_level = '0;
    logic [WaterW-1:0]  i_water_level = '0;
    logic [CornerW-1:0] i_corner_bits = '0;
    logic               i_double_height = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [HeightW-1:0] o_height;
    logic [WhW-1:0]     o_water_height;

    int fail_count;
    int pending;

    // Idle rates in percent, and long result hold-offs asked for by the request side.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_asked = 0;
    int hold_off_served = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    terrain_sloped_height dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_surface_present(i_surface_present),
        .i_base_level     (i_base_level),
        .i_water_level    (i_water_level),
        .i_corner_bits    (i_corner_bits),
        .i_double_height  (i_double_height),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_height         (o_height),
        .o_water_height   (o_water_height)
    );

    terrain_sloped_height_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_surface_present(i_surface_present),
        .i_base_level     (i_base_level),
        .i_water_level    (i_water_level),
        .i_corner_bits    (i_corner_bits),
        .i_double_height  (i_double_height),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_height         (o_height),
        .i_water_height   (o_water_height),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Result side: a long hold-off when one is asked for, random stalls otherwise.
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_off_served != hold_off_asked) begin
            hold_off_served = hold_off_served + 1;
            hold_off_left = LONG_HOLD_OFF - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without any handshake on either channel ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("[terrain_sloped_height] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic terrain_request_t make_request(
        input logic [PosW-1:0]    px,
        input logic [PosW-1:0]    py,
        input logic               present,
        input logic [BaseW-1:0]   base,
        input logic [WaterW-1:0]  water,
        input logic [CornerW-1:0] corners,
        input logic               dbl
    );
        terrain_request_t r;
        r.pos_x = px;
        r.pos_y = py;
        r.present = present;
        r.base = base;
        r.water = water;
        r.corners = corners;
        r.dbl = dbl;
        return r;
    endfunction

    // Mostly on-map points on tiles with a surface; some anywhere, some at the map edge.
    function automatic terrain_request_t random_request();
        terrain_request_t r;
        logic [31:0] rnd;
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) begin
            r.pos_x = PosW'($urandom_range(int'(MAP_LIMIT) - 1));
            r.pos_y = PosW'($urandom_range(int'(MAP_LIMIT) - 1));
        end else if (sel < 90) begin
            rnd = $urandom;
            r.pos_x = rnd[15:0];
            r.pos_y = rnd[31:16];
        end else begin
            r.pos_x = PosW'($urandom_range(int'(MAP_LIMIT) + 1, int'(MAP_LIMIT) - 4));
            r.pos_y = PosW'($urandom_range(int'(MAP_LIMIT) - 1));
            if ($urandom_range(1)) begin
                r.pos_y = r.pos_x;
                r.pos_x = PosW'($urandom_range(int'(MAP_LIMIT) - 1));
            end
        end
        rnd = $urandom;
        r.present = ($urandom_range(9) != 0);
        r.base    = rnd[7:0];
        r.water   = rnd[12:8];
        r.corners = rnd[16:13];
        r.dbl     = rnd[17];
        return r;
    endfunction

    // Offer one request, after an optional random gap; called and left at a falling edge.
    task automatic send_request(input terrain_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pos_x <= r.pos_x;
        i_pos_y <= r.pos_y;
        i_surface_present <= r.present;
        i_base_level <= r.base;
        i_water_level <= r.water;
        i_corner_bits <= r.corners;
        i_double_height <= r.dbl;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input bit with_hold_off);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (with_hold_off) hold_off_asked = hold_off_asked + 1;
        for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 47;

        // Flat and full tiles at the extremes of every field.
        send_request(make_request(16'd0, 16'd0, 1'b1, 8'd0, 5'd0, SLOPE_FLAT, 1'b0));
        send_request(make_request(MAP_LIMIT - 16'd1, MAP_LIMIT - 16'd1, 1'b1, 8'd255, 5'd31,
                                  SLOPE_FULL, 1'b1));
        // Off the map on either axis, negative coordinates included, and no surface.
        send_request(make_request(MAP_LIMIT, 16'd0, 1'b1, 8'd100, 5'd10, SLOPE_N, 1'b0));
        send_request(make_request(16'd0, MAP_LIMIT, 1'b1, 8'd100, 5'd10, SLOPE_S, 1'b0));
        send_request(make_request(16'hFFFF, 16'd5, 1'b1, 8'd255, 5'd31, SLOPE_NE, 1'b1));
        send_request(make_request(16'h8000, 16'h7FFF, 1'b1, 8'd1, 5'd1, SLOPE_W, 1'b0));
        send_request(make_request(16'd1000, 16'd2000, 1'b0, 8'd200, 5'd20, SLOPE_NS, 1'b0));

        // Every slope case but flat and full, at assorted subtile positions, steep flag off.
        for (int s = SLOPE_N; s <= SLOPE_NDN; s++)
            send_request(make_request(PosW'(s * 37 + 3000), PosW'(s * 53 + 100), 1'b1,
                                      BaseW'(s * 18), WaterW'(s), CornerW'(s), 1'b0));

        // Steep corner-down slopes at their highest points.
        send_request(make_request(16'd31, 16'd0, 1'b1, 8'd255, 5'd31, SLOPE_WDN, 1'b1));
        send_request(make_request(16'd63, 16'd63, 1'b1, 8'd255, 5'd31, SLOPE_SDN, 1'b1));
        send_request(make_request(16'd32, 16'd31, 1'b1, 8'd255, 5'd31, SLOPE_EDN, 1'b1));
        send_request(make_request(16'd0, 16'd0, 1'b1, 8'd255, 5'd31, SLOPE_NDN, 1'b1));

        run_phase(16, 47, 1'b0);
        run_phase(47, 16, 1'b1);
        run_phase(0, 0, 1'b1);
        i_in_valid <= 1'b0;

        // Drain, then give a late extra result time to show up.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("[terrain_sloped_height] OK");
        else
            $display("[terrain_sloped_height] ERROR");
        $finish;
    end

endmodule
